// ===== hw/rtl/csmc_pkg.sv =====
// csmc_pkg: shared types and constants for the clock/stopwatch mode controller
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package csmc_pkg;

  localparam int unsigned CfgIndexWidth = 8;
  localparam int unsigned CfgDataWidth  = 16;

  localparam logic [CfgIndexWidth-1:0] REG_SLOW_BLINK_MS = 8'd0;
  localparam logic [CfgIndexWidth-1:0] REG_FAST_BLINK_MS = 8'd1;

  typedef struct packed {
    logic        func;
    logic        btn_left;
    logic        btn_mid;
    logic        btn_right;
    logic [31:0] now_ms;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [13:0] fnd_value;
    logic [4:0]  clock_hours;
    logic [5:0]  clock_minutes;
    logic [5:0]  clock_seconds;
    logic [6:0]  sw_minutes;
    logic [5:0]  sw_seconds;
    logic [3:0]  sw_tenths;
    logic        clock_colon_shown;
    logic        sw_colon_a_shown;
    logic        sw_colon_b_shown;
  } res_item_t;

  typedef struct packed {
    logic [CfgIndexWidth-1:0] index;
    logic [CfgDataWidth-1:0]  wdata;
  } cfg_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/csmc_cmd_if.sv =====
// csmc_cmd_if: input item channel (valid/ready, one item per transfer)
// depends on csmc_pkg
`default_nettype none

interface csmc_cmd_if
  import csmc_pkg::*;
();
  logic      valid;
  logic      ready;
  cmd_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/csmc_res_if.sv =====
// csmc_res_if: result item channel (valid/ready, one result per transfer)
// depends on csmc_pkg
`default_nettype none

interface csmc_res_if
  import csmc_pkg::*;
();
  logic      valid;
  logic      ready;
  res_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/csmc_cfg_if.sv =====
// csmc_cfg_if: register write channel (valid/ready, index and write data)
// depends on csmc_pkg
`default_nettype none

interface csmc_cfg_if
  import csmc_pkg::*;
();
  logic      valid;
  logic      ready;
  cfg_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/clock_stopwatch_mode_controller_unit.sv =====
// clock_stopwatch_mode_controller_unit: time-of-day clock, stopwatch and mode controller
// depends on csmc_pkg, csmc_cmd_if, csmc_res_if, csmc_cfg_if
//
//   channel  dir  payload                                  transfer when
//   cmd      in   func, buttons, now_ms                    cmd.valid && cmd.ready
//   res      out  mode, fnd, clock, stopwatch, colons      res.valid && res.ready
//   cfg      in   register index, 16-bit write data        cfg.valid (ready held high)
//
// one item per cycle while cmd.ready holds; the result is registered at the transfer
// cmd.ready is high while the result register is empty or being taken this cycle
// a stalled result holds its register and blocks only further input transfers
// rst is synchronous; afterwards the clock reads 12:00:00, blink periods 500 and 50 ms
`default_nettype none

module clock_stopwatch_mode_controller_unit
  import csmc_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = 10
) (
  input  wire         clk,
  input  wire         rst,
  csmc_cmd_if.sink    cmd,
  csmc_res_if.source  res,
  csmc_cfg_if.sink    cfg
);

  typedef enum logic [2:0] {
    MODE_IDLE        = 3'd0,
    MODE_RUN         = 3'd1,
    MODE_SET_HOURS   = 3'd2,
    MODE_SET_MINUTES = 3'd3,
    MODE_SET_SECONDS = 3'd4
  } mode_t;

  localparam logic [3:0] TicksLimit = 4'(TICKS_PER_SECOND);

  logic [15:0] slow_blink_ms, fast_blink_ms;

  mode_t       mode,        mode_next;
  logic [4:0]  hours,       hours_next;
  logic [5:0]  minutes,     minutes_next;
  logic [5:0]  seconds,     seconds_next;
  logic [6:0]  sw_minutes,  sw_minutes_next;
  logic [5:0]  sw_seconds,  sw_seconds_next;
  logic [3:0]  sw_tenths,   sw_tenths_next;
  logic        running,     running_next;
  logic        setting,     setting_next;
  logic [3:0]  tick_div,    tick_div_next;
  logic        slow_blink,  slow_blink_next;
  logic        fast_blink,  fast_blink_next;
  logic [31:0] slow_mark,   slow_mark_next;
  logic [31:0] fast_mark,   fast_mark_next;

  logic        res_valid;
  res_item_t   res_data, res_data_next;

  logic        cmd_xfer;
  logic [31:0] slow_elapsed, fast_elapsed;
  logic [6:0]  sec_inc, min_inc, swsec_inc, swmin_inc;
  logic [5:0]  hr_inc;
  logic [4:0]  swten_inc;
  logic [3:0]  div_inc;
  logic [13:0] fnd;

  function automatic logic [5:0] adjust(input logic [5:0] v, input logic [5:0] top,
                                        input logic up, input logic down);
    logic [5:0] r;
    r = v;
    if (up) begin
      r = (r >= top) ? 6'd0 : r + 6'd1;
    end
    if (down) begin
      r = (r == 6'd0 || r > top) ? top : r - 6'd1;
    end
    return r;
  endfunction

  assign cmd.ready = !res_valid || res.ready;
  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;
  assign res.valid = res_valid;
  assign res.data  = res_data;

  assign slow_elapsed = cmd.data.now_ms - slow_mark;
  assign fast_elapsed = cmd.data.now_ms - fast_mark;

  always_comb begin
    mode_next       = mode;
    hours_next      = hours;
    minutes_next    = minutes;
    seconds_next    = seconds;
    sw_minutes_next = sw_minutes;
    sw_seconds_next = sw_seconds;
    sw_tenths_next  = sw_tenths;
    running_next    = running;
    setting_next    = setting;
    tick_div_next   = tick_div;
    slow_blink_next = slow_blink;
    fast_blink_next = fast_blink;
    slow_mark_next  = slow_mark;
    fast_mark_next  = fast_mark;
    sec_inc         = 7'd0;
    min_inc         = 7'd0;
    hr_inc          = 6'd0;
    swten_inc       = 5'd0;
    swsec_inc       = 7'd0;
    swmin_inc       = 7'd0;
    div_inc         = tick_div + 4'd1;

    if (!cmd.data.func) begin
      tick_div_next = div_inc;
      if (div_inc >= TicksLimit) begin
        tick_div_next = 4'd0;
        if (!setting) begin
          sec_inc = {1'b0, seconds} + 7'd1;
          min_inc = {1'b0, minutes};
          hr_inc  = {1'b0, hours};
          if (sec_inc >= 7'd60) begin
            sec_inc = 7'd0;
            min_inc = min_inc + 7'd1;
          end
          if (min_inc >= 7'd60) begin
            min_inc = 7'd0;
            hr_inc  = hr_inc + 6'd1;
          end
          if (hr_inc >= 6'd24) begin
            hr_inc = 6'd0;
          end
          seconds_next = sec_inc[5:0];
          minutes_next = min_inc[5:0];
          hours_next   = hr_inc[4:0];
        end
      end
      if (running) begin
        swten_inc = {1'b0, sw_tenths} + 5'd1;
        swsec_inc = {1'b0, sw_seconds};
        swmin_inc = sw_minutes;
        if (swten_inc >= 5'd10) begin
          swten_inc = 5'd0;
          swsec_inc = swsec_inc + 7'd1;
          if (swsec_inc >= 7'd60) begin
            swsec_inc = 7'd0;
            swmin_inc = swmin_inc + 7'd1;
          end
          if (swmin_inc >= 7'd100) begin
            swmin_inc = 7'd0;
          end
        end
        sw_tenths_next  = swten_inc[3:0];
        sw_seconds_next = swsec_inc[5:0];
        sw_minutes_next = swmin_inc;
      end
    end else begin
      if (slow_elapsed >= {16'd0, slow_blink_ms}) begin
        slow_mark_next  = slow_mark + {16'd0, slow_blink_ms};
        slow_blink_next = !slow_blink;
      end
      if (fast_elapsed >= {16'd0, fast_blink_ms}) begin
        fast_mark_next  = fast_mark + {16'd0, fast_blink_ms};
        fast_blink_next = !fast_blink;
      end
      unique case (mode)
        MODE_IDLE: begin
          running_next = 1'b0;
          setting_next = 1'b0;
          if (cmd.data.btn_left) begin
            mode_next = MODE_RUN;
          end
          if (cmd.data.btn_mid) begin
            sw_minutes_next = 7'd0;
            sw_seconds_next = 6'd0;
            sw_tenths_next  = 4'd0;
          end
          if (cmd.data.btn_right) begin
            setting_next = 1'b1;
            mode_next    = MODE_SET_HOURS;
          end
        end
        MODE_RUN: begin
          running_next = 1'b1;
          if (cmd.data.btn_left) begin
            running_next = 1'b0;
            mode_next    = MODE_IDLE;
          end
        end
        MODE_SET_HOURS: begin
          hours_next = 5'(adjust({1'b0, hours}, 6'd23, cmd.data.btn_left, cmd.data.btn_mid));
          if (cmd.data.btn_right) begin
            mode_next = MODE_SET_MINUTES;
          end
        end
        MODE_SET_MINUTES: begin
          minutes_next = adjust(minutes, 6'd59, cmd.data.btn_left, cmd.data.btn_mid);
          if (cmd.data.btn_right) begin
            mode_next = MODE_SET_SECONDS;
          end
        end
        MODE_SET_SECONDS: begin
          seconds_next = adjust(seconds, 6'd59, cmd.data.btn_left, cmd.data.btn_mid);
          if (cmd.data.btn_right) begin
            mode_next    = MODE_IDLE;
            setting_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (mode_next)
      MODE_IDLE, MODE_RUN: fnd = 14'({8'd0, sw_seconds_next} * 14'd100)
                                 + {10'd0, sw_tenths_next};
      MODE_SET_HOURS:      fnd = 14'd1111;
      MODE_SET_MINUTES:    fnd = 14'd2222;
      MODE_SET_SECONDS:    fnd = 14'd3333;
      default:             fnd = 14'd0;
    endcase
    res_data_next.mode              = mode_next;
    res_data_next.fnd_value         = fnd;
    res_data_next.clock_hours       = hours_next;
    res_data_next.clock_minutes     = minutes_next;
    res_data_next.clock_seconds     = seconds_next;
    res_data_next.sw_minutes        = sw_minutes_next;
    res_data_next.sw_seconds        = sw_seconds_next;
    res_data_next.sw_tenths         = sw_tenths_next;
    res_data_next.clock_colon_shown = !slow_blink_next || setting_next;
    res_data_next.sw_colon_a_shown  = !(slow_blink_next && running_next);
    res_data_next.sw_colon_b_shown  = !(fast_blink_next && running_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_blink_ms <= 16'd500;
      fast_blink_ms <= 16'd50;
    end else if (cfg.valid) begin
      if (cfg.data.index == REG_SLOW_BLINK_MS) begin
        slow_blink_ms <= cfg.data.wdata;
      end else if (cfg.data.index == REG_FAST_BLINK_MS) begin
        fast_blink_ms <= cfg.data.wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      hours      <= 5'd12;
      minutes    <= 6'd0;
      seconds    <= 6'd0;
      sw_minutes <= 7'd0;
      sw_seconds <= 6'd0;
      sw_tenths  <= 4'd0;
      running    <= 1'b0;
      setting    <= 1'b0;
      tick_div   <= 4'd0;
      slow_blink <= 1'b1;
      fast_blink <= 1'b1;
      slow_mark  <= 32'd0;
      fast_mark  <= 32'd0;
      res_valid  <= 1'b0;
    end else begin
      if (cmd_xfer) begin
        mode       <= mode_next;
        hours      <= hours_next;
        minutes    <= minutes_next;
        seconds    <= seconds_next;
        sw_minutes <= sw_minutes_next;
        sw_seconds <= sw_seconds_next;
        sw_tenths  <= sw_tenths_next;
        running    <= running_next;
        setting    <= setting_next;
        tick_div   <= tick_div_next;
        slow_blink <= slow_blink_next;
        fast_blink <= fast_blink_next;
        slow_mark  <= slow_mark_next;
        fast_mark  <= fast_mark_next;
        res_valid  <= 1'b1;
      end else if (res.ready) begin
        res_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      res_data <= res_data_next;
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for clock_stopwatch_mode_controller_unit
// depends on csmc_pkg, csmc_cmd_if, csmc_res_if, csmc_cfg_if and the unit itself
// a scoreboard class predicts every display transfer; tasks drive ticks, polls and blink periods
`default_nettype none

module tb_top
  import csmc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TicksPerSecond = 10;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_POLL = 1'b1;

  localparam logic [13:0] FND_SET_HOURS   = 14'd1111;
  localparam logic [13:0] FND_SET_MINUTES = 14'd2222;
  localparam logic [13:0] FND_SET_SECONDS = 14'd3333;

  typedef enum logic [2:0] {
    MODE_IDLE        = 3'd0,
    MODE_RUN         = 3'd1,
    MODE_SET_HOURS   = 3'd2,
    MODE_SET_MINUTES = 3'd3,
    MODE_SET_SECONDS = 3'd4
  } mode_e;

  class display_scoreboard;
    logic [15:0] slow_period;
    logic [15:0] fast_period;
    mode_e       mode;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [6:0]  sw_min;
    logic [5:0]  sw_sec;
    logic [3:0]  sw_ten;
    bit          running;
    bit          setting;
    logic [3:0]  tick_div;
    bit          slow_blink;
    bit          fast_blink;
    logic [31:0] slow_mark;
    logic [31:0] fast_mark;
    res_item_t   expected_displays[$];
    int unsigned errors;

    function new();
      slow_period = 16'd500;
      fast_period = 16'd50;
      mode        = MODE_IDLE;
      hours       = 5'd12;
      minutes     = '0;
      seconds     = '0;
      sw_min      = '0;
      sw_sec      = '0;
      sw_ten      = '0;
      running     = 1'b0;
      setting     = 1'b0;
      tick_div    = '0;
      slow_blink  = 1'b1;
      fast_blink  = 1'b1;
      slow_mark   = '0;
      fast_mark   = '0;
      errors      = 0;
    endfunction

    function int pending();
      return expected_displays.size();
    endfunction

    function void write_register(logic [CfgIndexWidth-1:0] index, logic [15:0] value);
      case (index)
        REG_SLOW_BLINK_MS: slow_period = value;
        REG_FAST_BLINK_MS: fast_period = value;
        default: ;
      endcase
    endfunction

    function int unsigned bump(int unsigned v, int unsigned top, bit up, bit down);
      if (up) v = (v >= top) ? 0 : v + 1;
      if (down) v = (v == 0 || v > top) ? top : v - 1;
      return v;
    endfunction

    function void advance_tick();
      tick_div = tick_div + 4'd1;
      if (tick_div >= TicksPerSecond) begin
        tick_div = '0;
        if (!setting) begin
          seconds = seconds + 6'd1;
          if (seconds >= 60) begin
            seconds = '0;
            minutes = minutes + 6'd1;
          end
          if (minutes >= 60) begin
            minutes = '0;
            hours = hours + 5'd1;
          end
          if (hours >= 24) hours = '0;
        end
      end
      if (running) begin
        sw_ten = sw_ten + 4'd1;
        if (sw_ten >= 10) begin
          sw_ten = '0;
          sw_sec = sw_sec + 6'd1;
          if (sw_sec >= 60) begin
            sw_sec = '0;
            sw_min = sw_min + 7'd1;
          end
          if (sw_min >= 100) sw_min = '0;
        end
      end
    endfunction

    function void apply_poll(bit l, bit m, bit r, logic [31:0] now);
      if ((now - slow_mark) >= {16'd0, slow_period}) begin
        slow_mark = slow_mark + {16'd0, slow_period};
        slow_blink = !slow_blink;
      end
      if ((now - fast_mark) >= {16'd0, fast_period}) begin
        fast_mark = fast_mark + {16'd0, fast_period};
        fast_blink = !fast_blink;
      end
      case (mode)
        MODE_IDLE: begin
          running = 1'b0;
          setting = 1'b0;
          if (l) mode = MODE_RUN;
          if (m) begin
            sw_min = '0;
            sw_sec = '0;
            sw_ten = '0;
          end
          if (r) begin
            setting = 1'b1;
            mode = MODE_SET_HOURS;
          end
        end
        MODE_RUN: begin
          running = 1'b1;
          if (l) begin
            running = 1'b0;
            mode = MODE_IDLE;
          end
        end
        MODE_SET_HOURS: begin
          hours = 5'(bump(hours, 23, l, m));
          if (r) mode = MODE_SET_MINUTES;
        end
        MODE_SET_MINUTES: begin
          minutes = 6'(bump(minutes, 59, l, m));
          if (r) mode = MODE_SET_SECONDS;
        end
        MODE_SET_SECONDS: begin
          seconds = 6'(bump(seconds, 59, l, m));
          if (r) begin
            mode = MODE_IDLE;
            setting = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    function void note_command(cmd_item_t c);
      res_item_t e;
      if (c.func == FUNC_TICK) advance_tick();
      else apply_poll(c.btn_left, c.btn_mid, c.btn_right, c.now_ms);
      e.mode = mode;
      case (mode)
        MODE_IDLE, MODE_RUN: e.fnd_value = 14'(sw_sec * 100 + sw_ten);
        MODE_SET_HOURS:      e.fnd_value = FND_SET_HOURS;
        MODE_SET_MINUTES:    e.fnd_value = FND_SET_MINUTES;
        MODE_SET_SECONDS:    e.fnd_value = FND_SET_SECONDS;
        default:             e.fnd_value = '0;
      endcase
      e.clock_hours       = hours;
      e.clock_minutes     = minutes;
      e.clock_seconds     = seconds;
      e.sw_minutes        = sw_min;
      e.sw_seconds        = sw_sec;
      e.sw_tenths         = sw_ten;
      e.clock_colon_shown = !slow_blink || setting;
      e.sw_colon_a_shown  = !(slow_blink && running);
      e.sw_colon_b_shown  = !(fast_blink && running);
      expected_displays.push_back(e);
    endfunction

    task report(string what);
      if (errors < 50) $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_display(res_item_t got);
      res_item_t want;
      if (expected_displays.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        want = expected_displays.pop_front();
        compare_field("mode", got.mode, want.mode);
        compare_field("fnd_value", got.fnd_value, want.fnd_value);
        compare_field("clock_hours", got.clock_hours, want.clock_hours);
        compare_field("clock_minutes", got.clock_minutes, want.clock_minutes);
        compare_field("clock_seconds", got.clock_seconds, want.clock_seconds);
        compare_field("sw_minutes", got.sw_minutes, want.sw_minutes);
        compare_field("sw_seconds", got.sw_seconds, want.sw_seconds);
        compare_field("sw_tenths", got.sw_tenths, want.sw_tenths);
        compare_field("clock_colon_shown", got.clock_colon_shown, want.clock_colon_shown);
        compare_field("sw_colon_a_shown", got.sw_colon_a_shown, want.sw_colon_a_shown);
        compare_field("sw_colon_b_shown", got.sw_colon_b_shown, want.sw_colon_b_shown);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  csmc_cmd_if cmd_ch ();
  csmc_res_if res_ch ();
  csmc_cfg_if cfg_ch ();

  clock_stopwatch_mode_controller_unit #(
    .TICKS_PER_SECOND(TicksPerSecond)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  display_scoreboard board = new();
  bit          quiet = 1'b0;
  int          sink_hold = 0;
  int unsigned items_sent = 0;
  logic [31:0] ms_now = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    rst          <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.data  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
  end

  // result side: random stall bursts plus a long hold requested by the stimulus
  initial begin
    int sink_gap;
    sink_gap = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (sink_hold > 0) begin
        res_ch.ready <= 1'b0;
        sink_hold--;
      end else if (sink_gap > 0) begin
        res_ch.ready <= 1'b0;
        sink_gap--;
      end else begin
        res_ch.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) sink_gap = $urandom_range(1, 10);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) board.check_display(res_ch.data);
  end

  function automatic cmd_item_t make_cmd(logic f, logic l, logic m, logic r, logic [31:0] ms);
    cmd_item_t c;
    c.func      = f;
    c.btn_left  = l;
    c.btn_mid   = m;
    c.btn_right = r;
    c.now_ms    = ms;
    return c;
  endfunction

  function automatic int unsigned ms_step();
    return ($urandom_range(0, 39) == 0) ? $urandom_range(0, 70000) : $urandom_range(0, 150);
  endfunction

  task automatic send_command(cmd_item_t c);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.data  <= c;
    cmd_ch.valid <= 1'b1;
    do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
    board.note_command(c);
    items_sent++;
  endtask

  task automatic send_tick();
    send_command(make_cmd(FUNC_TICK, 1'($urandom), 1'($urandom), 1'($urandom), $urandom));
  endtask

  task automatic send_poll(bit l, bit m, bit r, int unsigned step);
    ms_now = ms_now + step;
    send_command(make_cmd(FUNC_POLL, l, m, r, ms_now));
  endtask

  task automatic wait_for_results();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic set_blink_periods(logic [15:0] slow, logic [15:0] fast);
    cfg_ch.data  <= cfg_item_t'{index: REG_SLOW_BLINK_MS, wdata: slow};
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    board.write_register(REG_SLOW_BLINK_MS, slow);
    cfg_ch.data <= cfg_item_t'{index: REG_FAST_BLINK_MS, wdata: fast};
    do @(posedge clk); while (!cfg_ch.ready);
    board.write_register(REG_FAST_BLINK_MS, fast);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic return_to_idle();
    while (board.mode != MODE_IDLE) begin
      if (board.mode == MODE_RUN) send_poll(1, 0, 0, ms_step());
      else send_poll(0, 0, 1, ms_step());
    end
  endtask

  task automatic run_random(int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          return_to_idle();
          send_poll(1, 0, 0, ms_step());
          send_poll(0, 0, 0, ms_step());
          repeat ($urandom_range(3, 40)) begin
            if ($urandom_range(0, 7) == 0) send_poll(0, 1'($urandom), 1'($urandom), ms_step());
            else send_tick();
          end
          send_poll(1, 0, 0, ms_step());
          if ($urandom_range(0, 2) == 0) send_poll(0, 1, 0, ms_step());
        end
        3, 4, 5: begin
          return_to_idle();
          send_poll(0, 0, 1, ms_step());
          repeat (3) begin
            repeat ($urandom_range(0, 30)) begin
              case ($urandom_range(0, 5))
                0:       send_tick();
                1, 2:    send_poll(1, 0, 0, ms_step());
                3, 4:    send_poll(0, 1, 0, ms_step());
                default: send_poll(1, 1, 0, ms_step());
              endcase
            end
            send_poll(0, 0, 1, ms_step());
          end
          repeat ($urandom_range(0, 40)) send_tick();
        end
        6, 7, 8: begin
          repeat ($urandom_range(5, 30)) begin
            if ($urandom_range(0, 9) == 0) send_poll(0, 0, 0, ms_step());
            else send_tick();
          end
        end
        default: begin
          repeat ($urandom_range(1, 8))
            send_command(make_cmd(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                                  $urandom));
        end
      endcase
    end
  endtask

  initial begin
    logic [15:0] slow;
    logic [15:0] fast;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_blink_periods(16'd500, 16'd50);

    // ignored fields on a tick, blink thresholds, run/stop, clear, set modes with wrap
    send_command(make_cmd(FUNC_TICK, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF));
    send_poll(0, 0, 0, 0);
    send_poll(0, 0, 0, 499);
    send_poll(0, 0, 0, 1);
    send_poll(1, 0, 0, 100);
    send_poll(0, 0, 0, 100);
    send_tick();
    send_tick();
    send_poll(0, 1, 1, 100);
    send_poll(1, 0, 0, 100);
    send_poll(0, 1, 0, 100);
    send_poll(1, 1, 1, 100);
    send_poll(0, 1, 0, 10);
    send_poll(1, 1, 0, 10);
    send_poll(0, 0, 1, 10);
    send_poll(0, 1, 0, 10);
    send_poll(0, 0, 1, 10);
    send_poll(0, 1, 0, 10);
    send_tick();
    send_poll(1, 0, 0, 10);
    send_poll(0, 0, 1, 10);

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       begin slow = 16'd500;   fast = 16'd50;    end
        1:       begin slow = 16'd1;     fast = 16'd1;     end
        2:       begin slow = 16'hFFFF;  fast = 16'hFFFF;  end
        3:       begin slow = 16'd0;     fast = 16'd0;     end
        4:       begin slow = 16'd1;     fast = 16'hFFFF;  end
        5:       begin
          slow = 16'($urandom_range(1, 65535));
          fast = 16'($urandom_range(1, 65535));
        end
        default: begin slow = 16'($urandom_range(1, 1000));  fast = 16'($urandom_range(1, 200));   end
      endcase
      wait_for_results();
      set_blink_periods(slow, fast);
      if (phase == 2) ms_now = 32'hFFFF_F000;
      if (phase == 1) begin
        // long result stall while ticks keep coming, then a full drain
        sink_hold = 300;
        repeat (30) send_tick();
        wait_for_results();
      end
      run_random(130);
    end

    wait_for_results();
    quiet = 1'b1;
    set_blink_periods(16'd300, 16'd30);
    // stopwatch run long enough for its seconds to carry into minutes
    return_to_idle();
    send_poll(0, 1, 0, ms_step());
    send_poll(1, 0, 0, ms_step());
    send_poll(0, 0, 0, ms_step());
    repeat (600) send_tick();
    send_poll(1, 0, 0, ms_step());
    run_random(100);

    wait_for_results();
    repeat (4) @(posedge clk);
    if (board.errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/csmc_pkg.sv
hw/rtl/csmc_cmd_if.sv
hw/rtl/csmc_res_if.sv
hw/rtl/csmc_cfg_if.sv
hw/rtl/clock_stopwatch_mode_controller_unit.sv
bench/tb_top.sv
